/* hdl/wrns_pkg.sv */
// shared constants, codes and types of the windowed radius neighbor search unit
// no dependencies; imported by every other file of the block

package wrns_pkg;

  // parameter defaults
  localparam int unsigned MAX_POINTS_DEF  = 4096;
  localparam int unsigned MAX_BONDS_DEF   = 64;
  localparam int unsigned COORD_BITS_DEF  = 20;

  // fixed field widths
  localparam int unsigned COORD_W   = 20;
  localparam int unsigned INDEX_W   = 12;
  localparam int unsigned BOND_W    = 6;
  localparam int unsigned HORIZON_W = 44;
  localparam int unsigned WINDOW_W  = 13;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    STATUS_RESULT = 2'd0,
    STATUS_LOADED = 2'd1,
    STATUS_REJECT = 2'd2
  } status_e;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_SQ     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_THIRD_AXIS = 2'd2;

  // distance stage status toward the walk control
  typedef struct packed {
    logic valid;
    logic match;
  } hit_t;

endpackage

/* hdl/wrns_ram.sv */
// generic simple dual port ram, one write port and one registered read port
// uses wrns_pkg for its default width

module wrns_ram import wrns_pkg::*; #(
  parameter int unsigned WIDTH = 3 * COORD_BITS_DEF,
  parameter int unsigned DEPTH = MAX_POINTS_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/wrns_dist.sv */
// squared distance stage: holds the queried point, squares per axis, compares
// with the squared horizon; uses wrns_pkg (hit_t, widths)

module wrns_dist import wrns_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    flush_i,
  input  logic                    ld_ref_i,
  input  logic                    valid_i,
  input  logic [3*COORD_BITS-1:0] rdata_i,
  input  logic                    use_z_i,
  input  logic [HORIZON_W-1:0]    horizon_i,
  output hit_t                    hit_o
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned SQ_W  = 2 * CB + 1;
  localparam int unsigned SUM_W = SQ_W + 2;
  localparam int unsigned CMP_W = (SUM_W > HORIZON_W) ? SUM_W : HORIZON_W;

  logic [3*CB-1:0] ref_q;
  logic            valid_q;
  logic [SQ_W-1:0] sqx_q, sqy_q, sqz_q;
  logic [SUM_W-1:0] sum;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic signed [CB:0]     d;
    logic signed [2*CB+1:0] p;
    d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
    p = d * d;
    return p[SQ_W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (ld_ref_i) begin
      ref_q <= rdata_i;
    end
    if (adv_i) begin
      sqx_q <= sq_diff(rdata_i[CB-1:0], ref_q[CB-1:0]);
      sqy_q <= sq_diff(rdata_i[2*CB-1:CB], ref_q[2*CB-1:CB]);
      sqz_q <= use_z_i ? sq_diff(rdata_i[3*CB-1:2*CB], ref_q[3*CB-1:2*CB]) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (flush_i) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  assign sum = SUM_W'(sqx_q) + SUM_W'(sqy_q) + SUM_W'(sqz_q);

  assign hit_o.valid = valid_q;
  assign hit_o.match = valid_q && (CMP_W'(sum) <= CMP_W'(horizon_i));

endmodule

/* hdl/windowed_radius_neighbor_search_unit.sv */
// top level of the windowed radius neighbor search unit: walk control, point count,
// configuration and result register; uses wrns_pkg, wrns_ram and wrns_dist
//
// usage
//   input channel (in_valid_i/in_ready_o): one beat is a load (func 0) or a query (func 1).
//   a load writes x/y/z at the current point count (restart first rewinds it to zero)
//   and answers one beat, status loaded, or status reject when the store is full.
//   a query names a stored point q and walks indices max(0, q-window) up to but not
//   including min(count, q+window), skipping q itself; each point within the squared
//   horizon gives one beat with found set, in index order, the final one with last set.
//   after MAX_BONDS bonds a further hit ends the walk and sets overflow on the last beat.
//   a query finding nothing gives one empty beat; an unloaded index gives status reject.
//   config channel (cfg_valid_i/cfg_ready_o) is always ready; write only while idle.
// timing
//   load or reject: result registered in the cycle after the input beat
//   query: point q is fetched (read, then latched into the distance stage), then one memory
//   read per candidate through a pipe of read, square and compare, and one drain check before
//   the last beat; the single read port of the point memory limits the walk to one candidate
//   per cycle while the output is not stalled
//   a new input beat is taken only once the previous item is fully answered
// reset: point count zero, window zero, horizon zero, third axis on; the point memory
//   is not cleared, only entries below the count are ever read
// stalls: while a result waits in the output register and out_ready_i is low the
//   whole walk pipe freezes, memory read data included

module windowed_radius_neighbor_search_unit import wrns_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned MAX_BONDS  = MAX_BONDS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input items
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic                       restart_i,
  input  logic signed [COORD_W-1:0]  coord_x_i,
  input  logic signed [COORD_W-1:0]  coord_y_i,
  input  logic signed [COORD_W-1:0]  coord_z_i,
  input  logic [INDEX_W-1:0]         query_index_i,
  // results
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic                       found_o,
  output logic [INDEX_W-1:0]         neighbor_index_o,
  output logic [BOND_W-1:0]          bond_number_o,
  output logic                       overflow_o,
  output logic                       last_o,
  // configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [HORIZON_W-1:0]       cfg_data_i
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned PW    = 3 * CB;
  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned CW    = (CNT_W > WINDOW_W + 1) ? CNT_W : WINDOW_W + 1;
  localparam int unsigned N_W   = $clog2(MAX_BONDS + 1);

  // walk sequencer
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RDQ  = 2'd1;  // read the queried point
  localparam logic [1:0] ST_LDQ  = 2'd2;  // latch it into the distance stage
  localparam logic [1:0] ST_WALK = 2'd3;  // stream candidates

  logic [1:0] state_q, state_d;

  // configuration
  logic [HORIZON_W-1:0] horizon_q;
  logic [WINDOW_W-1:0]  window_q;
  logic                 use_z_q;

  // point count and walk bounds
  logic [CNT_W-1:0] count_q, count_d;
  logic [CW-1:0]    q_q, q_d;
  logic [CW-1:0]    k_q, k_d;
  logic [CW-1:0]    hi_q, hi_d;

  // index tags riding alongside the memory read and square stages
  logic             s1_valid_q, s1_valid_d;
  logic [IDX_W-1:0] s1_k_q, s1_k_d;
  logic [IDX_W-1:0] s2_k_q, s2_k_d;

  // bond list: one hit held back until we know whether it is the last
  logic [N_W-1:0]   n_q, n_d;
  logic             pend_valid_q, pend_valid_d;
  logic [IDX_W-1:0] pend_k_q, pend_k_d;
  logic [N_W-1:0]   pend_n_q, pend_n_d;

  // result register
  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic               found_q, found_d;
  logic [INDEX_W-1:0] nidx_q, nidx_d;
  logic [BOND_W-1:0]  bond_q, bond_d;
  logic               ovf_q, ovf_d;
  logic               last_q, last_d;
  logic               out_we;

  // memory and distance stage hookup
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [PW-1:0]    mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [PW-1:0]    mem_rdata;
  logic             ld_ref;
  logic             flush;
  hit_t             hit;

  logic             in_acc;
  logic             stall;
  logic             adv;
  logic [CNT_W-1:0] count_eff;
  logic             full;
  logic [CW-1:0]    q_ext, cnt_ext, win_ext, lo, hi_sum, hi;
  logic             issue_done;

  assign stall       = out_valid_q & ~out_ready_i;
  assign adv         = ~stall;
  assign in_ready_o  = (state_q == ST_IDLE) & adv;
  assign in_acc      = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;

  // load path: restart rewinds before the fullness check
  assign count_eff = restart_i ? '0 : count_q;
  assign full      = (count_eff == CNT_W'(MAX_POINTS));
  assign mem_we    = in_acc && (func_i == FUNC_LOAD) && !full;
  assign mem_waddr = count_eff[IDX_W-1:0];
  assign mem_wdata = {CB'($unsigned(coord_z_i)), CB'($unsigned(coord_y_i)),
                      CB'($unsigned(coord_x_i))};

  // query window, clamped at zero and at the point count
  assign q_ext   = CW'(query_index_i);
  assign cnt_ext = CW'(count_q);
  assign win_ext = CW'(window_q);
  assign lo      = (q_ext > win_ext) ? (q_ext - win_ext) : '0;
  assign hi_sum  = q_ext + win_ext;
  assign hi      = (hi_sum > cnt_ext) ? cnt_ext : hi_sum;

  assign issue_done = (k_q >= hi_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    q_d          = q_q;
    k_d          = k_q;
    hi_d         = hi_q;
    s1_valid_d   = s1_valid_q;
    s1_k_d       = s1_k_q;
    s2_k_d       = adv ? s1_k_q : s2_k_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_k_d     = pend_k_q;
    pend_n_d     = pend_n_q;
    mem_re       = 1'b0;
    mem_raddr    = k_q[IDX_W-1:0];
    ld_ref       = 1'b0;
    flush        = 1'b0;
    out_we       = 1'b0;
    status_d     = status_q;
    found_d      = found_q;
    nidx_d       = nidx_q;
    bond_d       = bond_q;
    ovf_d        = ovf_q;
    last_d       = last_q;

    unique case (state_q)
      ST_IDLE: begin
        s1_valid_d = 1'b0;
        if (in_acc) begin
          out_we   = 1'b1;
          found_d  = 1'b0;
          nidx_d   = '0;
          bond_d   = '0;
          ovf_d    = 1'b0;
          last_d   = 1'b1;
          if (func_i == FUNC_LOAD) begin
            count_d = count_eff;
            if (full) begin
              status_d = STATUS_REJECT;
            end else begin
              status_d = STATUS_LOADED;
              count_d  = count_eff + CNT_W'(1);
            end
          end else if (q_ext >= cnt_ext) begin
            status_d = STATUS_REJECT;
          end else begin
            // valid query: nothing to answer yet
            out_we       = 1'b0;
            q_d          = q_ext;
            k_d          = lo;
            hi_d         = hi;
            n_d          = '0;
            pend_valid_d = 1'b0;
            state_d      = ST_RDQ;
          end
        end
      end

      ST_RDQ: begin
        s1_valid_d = 1'b0;
        mem_re     = 1'b1;
        mem_raddr  = q_q[IDX_W-1:0];
        state_d    = ST_LDQ;
      end

      ST_LDQ: begin
        s1_valid_d = 1'b0;
        ld_ref     = 1'b1;
        state_d    = ST_WALK;
      end

      ST_WALK: begin
        if (adv) begin
          // issue the next candidate, the queried point itself is read but tagged invalid
          if (!issue_done) begin
            mem_re     = 1'b1;
            s1_valid_d = (k_q != q_q);
            s1_k_d     = k_q[IDX_W-1:0];
            k_d        = k_q + CW'(1);
          end else begin
            s1_valid_d = 1'b0;
          end

          if (hit.match) begin
            if (n_q == N_W'(MAX_BONDS)) begin
              // one hit beyond the list: close it with overflow and drop the rest
              out_we       = 1'b1;
              status_d     = STATUS_RESULT;
              found_d      = 1'b1;
              nidx_d       = INDEX_W'(pend_k_q);
              bond_d       = BOND_W'(pend_n_q);
              ovf_d        = 1'b1;
              last_d       = 1'b1;
              pend_valid_d = 1'b0;
              s1_valid_d   = 1'b0;
              flush        = 1'b1;
              state_d      = ST_IDLE;
            end else begin
              if (pend_valid_q) begin
                out_we   = 1'b1;
                status_d = STATUS_RESULT;
                found_d  = 1'b1;
                nidx_d   = INDEX_W'(pend_k_q);
                bond_d   = BOND_W'(pend_n_q);
                ovf_d    = 1'b0;
                last_d   = 1'b0;
              end
              pend_valid_d = 1'b1;
              pend_k_d     = s2_k_q;
              pend_n_d     = n_q;
              n_d          = n_q + N_W'(1);
            end
          end else if (issue_done && !s1_valid_q && !hit.valid) begin
            // pipe drained: release the held hit as last, or answer empty
            out_we       = 1'b1;
            status_d     = STATUS_RESULT;
            found_d      = pend_valid_q;
            nidx_d       = pend_valid_q ? INDEX_W'(pend_k_q) : '0;
            bond_d       = pend_valid_q ? BOND_W'(pend_n_q) : '0;
            ovf_d        = 1'b0;
            last_d       = 1'b1;
            pend_valid_d = 1'b0;
            state_d      = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_we) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      s1_valid_q   <= 1'b0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      s1_valid_q   <= s1_valid_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    q_q      <= q_d;
    k_q      <= k_d;
    hi_q     <= hi_d;
    s1_k_q   <= s1_k_d;
    s2_k_q   <= s2_k_d;
    pend_k_q <= pend_k_d;
    pend_n_q <= pend_n_d;
    status_q <= status_d;
    found_q  <= found_d;
    nidx_q   <= nidx_d;
    bond_q   <= bond_d;
    ovf_q    <= ovf_d;
    last_q   <= last_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizon_q <= '0;
      window_q  <= '0;
      use_z_q   <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_HORIZON_SQ:     horizon_q <= cfg_data_i;
        CFG_SEARCH_WINDOW:  window_q  <= cfg_data_i[WINDOW_W-1:0];
        CFG_USE_THIRD_AXIS: use_z_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  wrns_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_POINTS)
  ) u_points (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  wrns_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .flush_i  (flush),
    .ld_ref_i (ld_ref),
    .valid_i  (s1_valid_q),
    .rdata_i  (mem_rdata),
    .use_z_i  (use_z_q),
    .horizon_i(horizon_q),
    .hit_o    (hit)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_o          = found_q;
  assign neighbor_index_o = nidx_q;
  assign bond_number_o    = bond_q;
  assign overflow_o       = ovf_q;
  assign last_o           = last_q;

  // checks
  a_hit_only_walking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit.valid |-> (state_q == ST_WALK))
    else $error("distance stage busy outside a walk");

  a_bonds_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= N_W'(MAX_BONDS))
    else $error("bond count beyond limit");

  a_pend_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> ((pend_n_q + N_W'(1)) == n_q))
    else $error("held bond number out of step with bond count");

  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_IDLE))
    else $error("point store written during a query");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

endmodule
